@@ rtl/gno_pkg.sv @@
// gno_pkg: shared constants and types for the octave gradient noise block
// used by gradient_noise_3d_octaves and gno_checker, no dependencies
`default_nettype none

package gno_pkg;

    localparam int TABLE_SIZE     = 256;
    localparam int TABLE_AW       = $clog2(TABLE_SIZE);
    localparam int MAX_OCTAVES    = 8;
    localparam int LATTICE_OFFSET = 32'h1000;

    // 3.0 in unsigned Q.16, the constant term of the fade polynomial
    localparam logic [17:0] FADE_THREE = 18'h30000;

    typedef enum logic [1:0] {
        KIND_EVAL = 2'd0,
        KIND_PERM = 2'd1,
        KIND_GRAD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_FREQUENCY    = 2'd0,
        REG_AMPLITUDE    = 2'd1,
        REG_OCTAVE_COUNT = 2'd2
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_HASH,
        ST_DOT,
        ST_BLEND,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_VX,
        WB_VY,
        WB_VZ,
        WB_SX,
        WB_SY,
        WB_SZ,
        WB_ACC_LOAD,
        WB_ACC_ADD,
        WB_DOT,
        WB_BLEND,
        WB_SUM
    } t_wb;

    typedef struct packed {
        t_wb        op;
        logic [2:0] slot;
    } t_wb_cmd;

endpackage

`default_nettype wire

@@ rtl/gradient_noise_3d_octaves.sv @@
// gradient_noise_3d_octaves: 3d gradient noise summed over octaves, one shared multiplier
// depends on gno_pkg
// sequence: scale products, then per octave the hash/fade, dot and blend/weight multiplier
//   slots, then the drain and done states ahead of the o_valid strobe, N = octaves
// throughput: a new evaluate word is taken only once the single multiplier's sequence is idle;
//   table write words never raise busy
// reset: synchronous active low, resets sequencer and strobe, loads config register defaults;
//   the permutation and gradient tables are not cleared, results are never stalled
`default_nettype none

module gradient_noise_3d_octaves (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_perm_value,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    output logic               o_valid,
    output logic signed [31:0] o_noise_value,
    output logic               o_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = gno_pkg::TABLE_AW;
    localparam logic [AW-1:0] CELL_OFS =
        AW'(gno_pkg::LATTICE_OFFSET % gno_pkg::TABLE_SIZE);

    gno_pkg::t_state r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [2:0] r_corner, n_corner;

    logic [23:0] r_frequency;
    logic [23:0] r_amplitude;
    logic [3:0]  r_octave_count;

    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [23:0] r_vx, r_vy, r_vz;
    logic [16:0] r_sx, r_sy, r_sz;
    logic [AW-1:0] r_hash [0:5];
    logic signed [23:0] r_slot [0:7];
    logic signed [35:0] r_acc;
    logic [39:0] r_sum;
    logic [23:0] r_amp;
    logic [3:0]  r_oct_left;
    logic signed [57:0] r_prod;
    gno_pkg::t_wb_cmd r_wb, n_wb;
    logic [23:0] r_wb_base, n_wb_base;

    logic [7:0]  m_perm [0:gno_pkg::TABLE_SIZE-1];
    logic [47:0] m_grad [0:gno_pkg::TABLE_SIZE-1];
    logic [7:0]  r_pq;
    logic [47:0] r_gq;

    logic signed [32:0] w_mul_a;
    logic signed [24:0] w_mul_b;
    logic signed [57:0] w_prod;
    logic [AW-1:0] w_paddr, w_gaddr;
    logic [2:0]    w_gcorner;
    logic          w_accept;
    logic [3:0]    w_count;
    logic [AW-1:0] w_bx0, w_bx1, w_by0, w_by1, w_bz0, w_bz1;
    logic signed [16:0] w_rx, w_ry, w_rz;
    logic signed [35:0] w_dot_sum;

    function automatic logic [17:0] fade_factor(input logic [15:0] r);
        fade_factor = gno_pkg::FADE_THREE - {1'b0, r, 1'b0};
    endfunction

    assign busy     = (r_state != gno_pkg::ST_IDLE);
    assign pready   = 1'b1;
    assign w_accept = start && !busy;
    assign w_count  = (int'(r_octave_count) > gno_pkg::MAX_OCTAVES) ?
                      4'(gno_pkg::MAX_OCTAVES) : r_octave_count;

    assign w_bx0 = r_vx[23:16] + CELL_OFS;
    assign w_by0 = r_vy[23:16] + CELL_OFS;
    assign w_bz0 = r_vz[23:16] + CELL_OFS;
    assign w_bx1 = w_bx0 + AW'(1);
    assign w_by1 = w_by0 + AW'(1);
    assign w_bz1 = w_bz0 + AW'(1);

    // far corner offset r - 1.0 is the fraction with the sign bit set
    assign w_rx = {r_corner[0], r_vx[15:0]};
    assign w_ry = {r_corner[1], r_vy[15:0]};
    assign w_rz = {r_corner[2], r_vz[15:0]};

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_dot_sum = r_acc + $signed(r_prod[35:0]);
    assign w_gaddr   = r_hash[3'd2 + {1'b0, w_gcorner[1:0]}] +
                       (w_gcorner[2] ? w_bz1 : w_bz0);

    // config read
    always_comb begin
        case (paddr[3:2])
            gno_pkg::REG_FREQUENCY:    prdata = {8'b0, r_frequency};
            gno_pkg::REG_AMPLITUDE:    prdata = {8'b0, r_amplitude};
            gno_pkg::REG_OCTAVE_COUNT: prdata = {28'b0, r_octave_count};
            default:                   prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_corner = r_corner;
        case (r_state)
            gno_pkg::ST_IDLE: begin
                n_step   = '0;
                n_corner = '0;
                if (w_accept && i_kind == gno_pkg::KIND_EVAL) begin
                    n_state = gno_pkg::ST_SCALE;
                end
            end
            gno_pkg::ST_SCALE: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd2) begin
                    n_step  = '0;
                    n_state = (r_oct_left == '0) ? gno_pkg::ST_DRAIN : gno_pkg::ST_HASH;
                end
            end
            gno_pkg::ST_HASH: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd6) begin
                    n_step   = '0;
                    n_corner = '0;
                    n_state  = gno_pkg::ST_DOT;
                end
            end
            gno_pkg::ST_DOT: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd2) begin
                    n_step   = '0;
                    n_corner = r_corner + 3'd1;
                    if (r_corner == 3'd7) begin
                        n_state = gno_pkg::ST_BLEND;
                    end
                end
            end
            gno_pkg::ST_BLEND: begin
                n_step = r_step + 4'd1;
                if (r_step == 4'd9) begin
                    n_step  = '0;
                    n_state = (r_oct_left == 4'd1) ? gno_pkg::ST_DRAIN : gno_pkg::ST_HASH;
                end
            end
            gno_pkg::ST_DRAIN: n_state = gno_pkg::ST_DONE;
            gno_pkg::ST_DONE:  n_state = gno_pkg::ST_IDLE;
            default:           n_state = gno_pkg::ST_IDLE;
        endcase
    end

    // multiplier operands, table addresses and write-back command per step
    always_comb begin
        w_mul_a   = '0;
        w_mul_b   = '0;
        n_wb      = '{op: gno_pkg::WB_NONE, slot: 3'd0};
        n_wb_base = '0;
        w_paddr   = w_bx0;
        w_gcorner = r_corner;
        case (r_state)
            gno_pkg::ST_SCALE: begin
                w_mul_b = {1'b0, r_frequency};
                case (r_step[1:0])
                    2'd0: begin
                        w_mul_a = 33'(r_cx);
                        n_wb.op = gno_pkg::WB_VX;
                    end
                    2'd1: begin
                        w_mul_a = 33'(r_cy);
                        n_wb.op = gno_pkg::WB_VY;
                    end
                    default: begin
                        w_mul_a = 33'(r_cz);
                        n_wb.op = gno_pkg::WB_VZ;
                    end
                endcase
            end
            gno_pkg::ST_HASH: begin
                w_gcorner = '0;
                case (r_step)
                    4'd0: begin
                        w_mul_a = {17'b0, r_vx[15:0]};
                        w_mul_b = {9'b0, r_vx[15:0]};
                        w_paddr = w_bx0;
                    end
                    4'd1: begin
                        w_mul_a = {17'b0, r_prod[31:16]};
                        w_mul_b = {7'b0, fade_factor(r_vx[15:0])};
                        n_wb.op = gno_pkg::WB_SX;
                        w_paddr = w_bx1;
                    end
                    4'd2: begin
                        w_mul_a = {17'b0, r_vy[15:0]};
                        w_mul_b = {9'b0, r_vy[15:0]};
                        w_paddr = r_hash[0] + w_by0;
                    end
                    4'd3: begin
                        w_mul_a = {17'b0, r_prod[31:16]};
                        w_mul_b = {7'b0, fade_factor(r_vy[15:0])};
                        n_wb.op = gno_pkg::WB_SY;
                        w_paddr = r_hash[1] + w_by0;
                    end
                    4'd4: begin
                        w_mul_a = {17'b0, r_vz[15:0]};
                        w_mul_b = {9'b0, r_vz[15:0]};
                        w_paddr = r_hash[0] + w_by1;
                    end
                    4'd5: begin
                        w_mul_a = {17'b0, r_prod[31:16]};
                        w_mul_b = {7'b0, fade_factor(r_vz[15:0])};
                        n_wb.op = gno_pkg::WB_SZ;
                        w_paddr = r_hash[1] + w_by1;
                    end
                    default: ;
                endcase
            end
            gno_pkg::ST_DOT: begin
                case (r_step[1:0])
                    2'd0: begin
                        w_mul_a = 33'(w_rx);
                        w_mul_b = 25'($signed(r_gq[47:32]));
                        n_wb.op = gno_pkg::WB_ACC_LOAD;
                    end
                    2'd1: begin
                        w_mul_a = 33'(w_ry);
                        w_mul_b = 25'($signed(r_gq[31:16]));
                        n_wb.op = gno_pkg::WB_ACC_ADD;
                    end
                    default: begin
                        w_mul_a   = 33'(w_rz);
                        w_mul_b   = 25'($signed(r_gq[15:0]));
                        n_wb.op   = gno_pkg::WB_DOT;
                        n_wb.slot = r_corner;
                        // fetch next corner gradient for the following slot
                        w_gcorner = r_corner + 3'd1;
                    end
                endcase
            end
            gno_pkg::ST_BLEND: begin
                // blend tree, result lands in the lower slot of each pair
                case (r_step)
                    4'd0: begin
                        w_mul_a   = 33'(r_slot[1] - r_slot[0]);
                        w_mul_b   = {8'b0, r_sx};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd0};
                        n_wb_base = r_slot[0];
                    end
                    4'd1: begin
                        w_mul_a   = 33'(r_slot[3] - r_slot[2]);
                        w_mul_b   = {8'b0, r_sx};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd2};
                        n_wb_base = r_slot[2];
                    end
                    4'd2: begin
                        w_mul_a   = 33'(r_slot[5] - r_slot[4]);
                        w_mul_b   = {8'b0, r_sx};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd4};
                        n_wb_base = r_slot[4];
                    end
                    4'd3: begin
                        w_mul_a   = 33'(r_slot[7] - r_slot[6]);
                        w_mul_b   = {8'b0, r_sx};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd6};
                        n_wb_base = r_slot[6];
                    end
                    4'd4: begin
                        w_mul_a   = 33'(r_slot[2] - r_slot[0]);
                        w_mul_b   = {8'b0, r_sy};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd0};
                        n_wb_base = r_slot[0];
                    end
                    4'd5: begin
                        w_mul_a   = 33'(r_slot[6] - r_slot[4]);
                        w_mul_b   = {8'b0, r_sy};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd4};
                        n_wb_base = r_slot[4];
                    end
                    4'd7: begin
                        w_mul_a   = 33'(r_slot[4] - r_slot[0]);
                        w_mul_b   = {8'b0, r_sz};
                        n_wb      = '{op: gno_pkg::WB_BLEND, slot: 3'd0};
                        n_wb_base = r_slot[0];
                    end
                    4'd9: begin
                        w_mul_a = 33'(r_slot[0]);
                        w_mul_b = {1'b0, r_amp};
                        n_wb.op = gno_pkg::WB_SUM;
                    end
                    default: ;  // bubbles wait for the previous write-back
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= gno_pkg::ST_IDLE;
            r_step         <= '0;
            r_corner       <= '0;
            r_wb           <= '{op: gno_pkg::WB_NONE, slot: 3'd0};
            r_frequency    <= 24'd65536;
            r_amplitude    <= 24'd65536;
            r_octave_count <= 4'd1;
            o_valid        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_corner <= n_corner;
            r_wb     <= n_wb;
            o_valid  <= (r_state == gno_pkg::ST_DONE);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    gno_pkg::REG_FREQUENCY:    r_frequency    <= pwdata[23:0];
                    gno_pkg::REG_AMPLITUDE:    r_amplitude    <= pwdata[23:0];
                    gno_pkg::REG_OCTAVE_COUNT: r_octave_count <= pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod    <= w_prod;
        r_wb_base <= n_wb_base;

        if (w_accept && i_kind == gno_pkg::KIND_EVAL) begin
            r_cx       <= i_coord_x;
            r_cy       <= i_coord_y;
            r_cz       <= i_coord_z;
            r_sum      <= '0;
            r_amp      <= r_amplitude;
            r_oct_left <= w_count;
        end

        if (r_state == gno_pkg::ST_HASH && r_step != 4'd0) begin
            r_hash[3'(r_step - 4'd1)] <= r_pq;
        end

        // next octave: point doubles, weight halves
        if (r_state == gno_pkg::ST_BLEND && r_step == 4'd9) begin
            r_vx       <= {r_vx[22:0], 1'b0};
            r_vy       <= {r_vy[22:0], 1'b0};
            r_vz       <= {r_vz[22:0], 1'b0};
            r_amp      <= {1'b0, r_amp[23:1]};
            r_oct_left <= r_oct_left - 4'd1;
        end

        case (r_wb.op)
            gno_pkg::WB_VX:       r_vx  <= r_prod[39:16];
            gno_pkg::WB_VY:       r_vy  <= r_prod[39:16];
            gno_pkg::WB_VZ:       r_vz  <= r_prod[39:16];
            gno_pkg::WB_SX:       r_sx  <= r_prod[32:16];
            gno_pkg::WB_SY:       r_sy  <= r_prod[32:16];
            gno_pkg::WB_SZ:       r_sz  <= r_prod[32:16];
            gno_pkg::WB_ACC_LOAD: r_acc <= $signed(r_prod[35:0]);
            gno_pkg::WB_ACC_ADD:  r_acc <= r_acc + $signed(r_prod[35:0]);
            gno_pkg::WB_DOT: begin
                r_slot[r_wb.slot] <= $signed({{2{w_dot_sum[35]}}, w_dot_sum[35:14]});
            end
            gno_pkg::WB_BLEND: begin
                r_slot[r_wb.slot] <= $signed(r_wb_base + r_prod[39:16]);
            end
            gno_pkg::WB_SUM:      r_sum <= r_sum + r_prod[55:16];
            default: ;
        endcase

        if (r_state == gno_pkg::ST_DONE) begin
            if (r_sum[39:31] != {9{r_sum[39]}}) begin
                o_noise_value <= r_sum[39] ? 32'sh80000000 : 32'sh7FFFFFFF;
                o_saturated   <= 1'b1;
            end else begin
                o_noise_value <= $signed(r_sum[31:0]);
                o_saturated   <= 1'b0;
            end
        end
    end

    // permutation and gradient tables
    always_ff @(posedge i_clk) begin
        if (w_accept && i_kind == gno_pkg::KIND_PERM) begin
            m_perm[i_table_index[AW-1:0]] <= i_perm_value;
        end
        r_pq <= m_perm[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_kind == gno_pkg::KIND_GRAD) begin
            m_grad[i_table_index[AW-1:0]] <= {i_grad_x, i_grad_y, i_grad_z};
        end
        r_gq <= m_grad[w_gaddr];
    end

endmodule

`default_nettype wire

@@ rtl/gno_checker.sv @@
// gno_assert: port-level checks for gradient_noise_3d_octaves, attached by bind
// depends on gno_pkg and the top level's ports
`default_nettype none

module gno_assert (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_kind,
    input logic        o_valid,
    input logic [31:0] o_noise_value,
    input logic        o_saturated,
    input logic        pready
);

    // result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // an accepted evaluate word starts the sequencer
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == gno_pkg::KIND_EVAL) |=> busy)
        else $error("evaluate word accepted but block not busy");

    // a result appears only once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    // a clipped result sits at one of the rails
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_noise_value == 32'h7FFFFFFF || o_noise_value == 32'h80000000))
        else $error("saturated result not at a rail");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind gradient_noise_3d_octaves gno_assert u_gno_assert (.*);

`default_nettype wire
